[rtl/core/yrfb_pkg.sv]
// shared types, constants and helpers for the yuyv to rgb framebuffer writer
// no dependencies; used by every module of the block
package yrfb_pkg;

  localparam int CFG_W    = 13;
  localparam int ADDR_W   = 26;
  localparam int PIX_W    = 24;
  localparam int PROD_W   = 20;
  localparam int SUM_W    = 21;
  localparam int MAX_DIMENSION_DEF = 4096;

  // q10 conversion coefficients
  localparam logic signed [PROD_W-1:0] COEF_R_V = PROD_W'(1441);
  localparam logic signed [PROD_W-1:0] COEF_G_U = PROD_W'(354);
  localparam logic signed [PROD_W-1:0] COEF_G_V = PROD_W'(734);
  localparam logic signed [PROD_W-1:0] COEF_B_U = PROD_W'(1822);

  localparam logic [CFG_W-1:0] DISPLAY_WIDTH_RST = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST   = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST  = CFG_W'(480);

  typedef enum logic [1:0] {
    MODE_RGB565 = 2'd0,
    MODE_BGR24  = 2'd1,
    MODE_BGRX32 = 2'd2,
    MODE_NONE   = 2'd3
  } pixel_mode_t;

  typedef enum logic [1:0] {
    REG_DISPLAY_WIDTH = 2'd0,
    REG_FRAME_WIDTH   = 2'd1,
    REG_FRAME_HEIGHT  = 2'd2,
    REG_PIXEL_MODE    = 2'd3
  } cfg_reg_t;

  // what the address walker hands to the pipeline for one item
  typedef struct packed {
    logic [ADDR_W-1:0] addr_part;
    logic [ADDR_W-1:0] offset;
    logic              last;
  } addr_info_t;

  function automatic logic [2:0] bpp_of(input pixel_mode_t mode);
    case (mode)
      MODE_RGB565: bpp_of = 3'd2;
      MODE_BGR24:  bpp_of = 3'd3;
      default:     bpp_of = 3'd4;
    endcase
  endfunction

  // multiply by bytes per pixel with shifts and one add
  function automatic logic [ADDR_W-1:0] scale_bpp(input logic [ADDR_W-1:0] x,
                                                  input pixel_mode_t mode);
    case (mode)
      MODE_RGB565: scale_bpp = x << 1;
      MODE_BGR24:  scale_bpp = (x << 1) + x;
      default:     scale_bpp = x << 2;
    endcase
  endfunction

endpackage

[rtl/core/yrfb_lane.sv]
// one conversion lane: luma +/- the chroma products, clamps and packs a pixel
// depends on yrfb_pkg
module yrfb_lane (
  input  logic [7:0]                          luma,
  input  logic signed [yrfb_pkg::PROD_W-1:0]  prod_r,
  input  logic signed [yrfb_pkg::PROD_W-1:0]  prod_g,
  input  logic signed [yrfb_pkg::PROD_W-1:0]  prod_b,
  input  logic                                is565,
  output logic [yrfb_pkg::PIX_W-1:0]          pixel
);
  import yrfb_pkg::*;

  logic signed [SUM_W-1:0] luma_q10;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_b;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  function automatic logic [7:0] clamp_q10(input logic signed [SUM_W-1:0] t);
    if (t[SUM_W-1]) begin
      clamp_q10 = 8'd0;
    end else if (t[SUM_W-2:18] != '0) begin
      clamp_q10 = 8'd255;
    end else begin
      clamp_q10 = t[17:10];
    end
  endfunction

  assign luma_q10 = $signed({{(SUM_W-18){1'b0}}, luma, 10'b0});
  assign sum_r = luma_q10 + SUM_W'(prod_r);
  assign sum_g = luma_q10 - SUM_W'(prod_g);
  assign sum_b = luma_q10 + SUM_W'(prod_b);

  assign red   = clamp_q10(sum_r);
  assign green = clamp_q10(sum_g);
  assign blue  = clamp_q10(sum_b);

  assign pixel = is565 ? {8'd0, red[7:3], green[7:2], blue[7:3]}
                       : {red, green, blue};

endmodule

[rtl/core/yrfb_addr.sv]
// address walker: column and row counters, row base, centering offset, frame end
// depends on yrfb_pkg
module yrfb_addr #(
  parameter int MAX_DIMENSION = yrfb_pkg::MAX_DIMENSION_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  yrfb_pkg::pixel_mode_t        mode,
  input  logic [yrfb_pkg::CFG_W-1:0]   display_width,
  input  logic [yrfb_pkg::CFG_W-1:0]   frame_width,
  input  logic [yrfb_pkg::CFG_W-1:0]   frame_height,
  output yrfb_pkg::addr_info_t         info
);
  import yrfb_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int COL_W = $clog2(MAX_DIMENSION / 2);
  localparam int ROW_W = $clog2(MAX_DIMENSION);
  localparam int SAT_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam logic [SAT_W-1:0] MAX_SAT = SAT_W'(MAX_DIMENSION);

  logic [COL_W-1:0]  pair_column, pair_column_next;
  logic [ROW_W-1:0]  row_index, row_index_next;
  logic [ADDR_W-1:0] row_base_address, row_base_address_next;

  logic [DIM_W-1:0]  dw_sat, fw_sat, fh_sat;
  logic [DIM_W-1:0]  pairs, rows, half_gap;
  logic              last_col, last_row;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v);
    if (SAT_W'(v) > MAX_SAT) begin
      sat_dim = DIM_W'(MAX_SAT);
    end else begin
      sat_dim = DIM_W'(v);
    end
  endfunction

  assign dw_sat = sat_dim(display_width);
  assign fw_sat = sat_dim(frame_width);
  assign fh_sat = sat_dim(frame_height);

  // tiny frames still count as one pair and one row
  assign pairs = ((fw_sat >> 1) == '0) ? DIM_W'(1) : (fw_sat >> 1);
  assign rows  = (fh_sat == '0) ? DIM_W'(1) : fh_sat;

  assign last_col = (DIM_W'(pair_column) + DIM_W'(1)) >= pairs;
  assign last_row = (DIM_W'(row_index) + DIM_W'(1)) >= rows;

  // frame wider than the display is left-aligned
  assign half_gap = (dw_sat > fw_sat) ? ((dw_sat - fw_sat) >> 1) : '0;

  assign info.offset    = scale_bpp(ADDR_W'(half_gap), mode);
  assign info.addr_part = row_base_address
                          + scale_bpp(ADDR_W'({pair_column, 1'b0}), mode);
  assign info.last      = last_col && last_row;

  always_comb begin
    pair_column_next      = pair_column;
    row_index_next        = row_index;
    row_base_address_next = row_base_address;
    if (advance) begin
      if (!last_col) begin
        pair_column_next = pair_column + COL_W'(1);
      end else if (!last_row) begin
        pair_column_next      = '0;
        row_index_next        = row_index + ROW_W'(1);
        row_base_address_next = row_base_address + scale_bpp(ADDR_W'(dw_sat), mode);
      end else begin
        pair_column_next      = '0;
        row_index_next        = '0;
        row_base_address_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column      <= '0;
      row_index        <= '0;
      row_base_address <= '0;
    end else begin
      pair_column      <= pair_column_next;
      row_index        <= row_index_next;
      row_base_address <= row_base_address_next;
    end
  end

endmodule

[rtl/core/yuyv_to_rgb_framebuffer.sv]
// top level of the yuyv to rgb framebuffer writer: config registers, pipeline, lanes
// depends on yrfb_pkg, yrfb_addr and yrfb_lane
//
// Takes one YUYV macropixel per clock while not stalled and returns both converted
// pixels, packed as RGB565, 24-bit BGR or 32-bit BGRx, with the framebuffer byte
// address of the first pixel (frame centered on the display, left-aligned when
// wider) and a frame_end flag on the last pair. Throughput is one item per cycle
// while out_stall is low. One stage forms the chroma products and the address, the
// second runs two conversion lanes (one per pixel) into the output register. In
// pixel_mode 3 items are taken and dropped and the counters hold. Registers are
// written through the cfg channel, which is always ready; the user must write them
// only while no item is in flight, and the block itself does not enforce it.
module yuyv_to_rgb_framebuffer #(
  parameter int MAX_DIMENSION = yrfb_pkg::MAX_DIMENSION_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [yrfb_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    luma_first,
  input  logic [7:0]                    chroma_blue,
  input  logic [7:0]                    luma_second,
  input  logic [7:0]                    chroma_red,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [yrfb_pkg::ADDR_W-1:0]   byte_address,
  output logic [yrfb_pkg::PIX_W-1:0]    pixel_first,
  output logic [yrfb_pkg::PIX_W-1:0]    pixel_second,
  output logic [1:0]                    bytes_written,
  output logic [2:0]                    pixel_stride,
  output logic                          frame_end
);
  import yrfb_pkg::*;

  logic [CFG_W-1:0] display_width, frame_width, frame_height;
  pixel_mode_t      pixel_mode;

  logic accept, advance, move_out;
  addr_info_t info;

  logic signed [7:0]        du, dv;
  logic signed [PROD_W-1:0] du_ext, dv_ext;

  // first stage
  logic                     s1_valid;
  logic [7:0]               s1_luma0, s1_luma1;
  logic signed [PROD_W-1:0] s1_prod_r, s1_prod_g, s1_prod_b;
  pixel_mode_t              s1_mode;
  addr_info_t               s1_info;

  logic [PIX_W-1:0] lane0_pixel, lane1_pixel;
  logic             s1_is565;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width <= DISPLAY_WIDTH_RST;
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
      pixel_mode    <= MODE_BGRX32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DISPLAY_WIDTH: display_width <= cfg_data;
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        REG_PIXEL_MODE:    pixel_mode    <= pixel_mode_t'(cfg_data[1:0]);
      endcase
    end
  end

  // handshake
  assign move_out = !out_valid || !out_stall;
  assign in_stall = s1_valid && !move_out;
  assign accept   = in_valid && !in_stall;
  assign advance  = accept && (pixel_mode != MODE_NONE);

  yrfb_addr #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_addr (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .mode          (pixel_mode),
    .display_width (display_width),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .info          (info)
  );

  // sample minus 128 is the sample with its top bit flipped, read as signed
  assign du     = $signed({~chroma_blue[7], chroma_blue[6:0]});
  assign dv     = $signed({~chroma_red[7], chroma_red[6:0]});
  assign du_ext = PROD_W'(du);
  assign dv_ext = PROD_W'(dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_luma0  <= luma_first;
      s1_luma1  <= luma_second;
      s1_prod_r <= dv_ext * COEF_R_V;
      s1_prod_g <= du_ext * COEF_G_U + dv_ext * COEF_G_V;
      s1_prod_b <= du_ext * COEF_B_U;
      s1_mode   <= pixel_mode;
      s1_info   <= info;
    end
  end

  assign s1_is565 = (s1_mode == MODE_RGB565);

  yrfb_lane u_lane0 (
    .luma   (s1_luma0),
    .prod_r (s1_prod_r),
    .prod_g (s1_prod_g),
    .prod_b (s1_prod_b),
    .is565  (s1_is565),
    .pixel  (lane0_pixel)
  );

  yrfb_lane u_lane1 (
    .luma   (s1_luma1),
    .prod_r (s1_prod_r),
    .prod_g (s1_prod_g),
    .prod_b (s1_prod_b),
    .is565  (s1_is565),
    .pixel  (lane1_pixel)
  );

  // merge the lanes with the address into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_out) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out && s1_valid) begin
      byte_address  <= s1_info.addr_part + s1_info.offset;
      pixel_first   <= lane0_pixel;
      pixel_second  <= lane1_pixel;
      bytes_written <= s1_is565 ? 2'd2 : 2'd3;
      pixel_stride  <= bpp_of(s1_mode);
      frame_end     <= s1_info.last;
    end
  end

endmodule

[rtl/core/yrfb_checker.sv]
// port-level checker for yuyv_to_rgb_framebuffer, attached by the bind below
// depends on yrfb_pkg and the top level's ports
module yrfb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [1:0]                    cfg_index,
  input logic [yrfb_pkg::CFG_W-1:0]    cfg_data,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [7:0]                    luma_first,
  input logic [7:0]                    chroma_blue,
  input logic [7:0]                    luma_second,
  input logic [7:0]                    chroma_red,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [yrfb_pkg::ADDR_W-1:0]   byte_address,
  input logic [yrfb_pkg::PIX_W-1:0]    pixel_first,
  input logic [yrfb_pkg::PIX_W-1:0]    pixel_second,
  input logic [1:0]                    bytes_written,
  input logic [2:0]                    pixel_stride,
  input logic                          frame_end
);

  // stride and byte count always describe the same mode
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((bytes_written == 2'd2) == (pixel_stride == 3'd2)))
    else $error("bytes_written and pixel_stride disagree");

  // rgb565 leaves the upper byte of both pixels clear
  assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_stride == 3'd2 |->
      pixel_first[23:16] == 8'd0 && pixel_second[23:16] == 8'd0)
    else $error("rgb565 pixel has upper byte set");

  // reset leaves no item on the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // a held result keeps its address and flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(byte_address) && $stable(frame_end))
    else $error("stalled item changed");

endmodule

bind yuyv_to_rgb_framebuffer yrfb_checker u_yrfb_checker (.*);

[tb/yrfb_pixel_checker.sv]
`timescale 1ns / 1ps
// checker for the yuyv to rgb framebuffer writer: follows register writes, predicts each
// pixel pair from the accepted items and compares it with what the block returns
// depends on yrfb_pkg
module yrfb_pixel_checker #(
  parameter int MAX_DIM = yrfb_pkg::MAX_DIMENSION_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [yrfb_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  luma_first,
  input  logic [7:0]                  chroma_blue,
  input  logic [7:0]                  luma_second,
  input  logic [7:0]                  chroma_red,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [yrfb_pkg::ADDR_W-1:0] byte_address,
  input  logic [yrfb_pkg::PIX_W-1:0]  pixel_first,
  input  logic [yrfb_pkg::PIX_W-1:0]  pixel_second,
  input  logic [1:0]                  bytes_written,
  input  logic [2:0]                  pixel_stride,
  input  logic                        frame_end,
  output int                          fail_count,
  output int                          pending,
  output int                          results_checked
);
  import yrfb_pkg::*;

  localparam int K_RV = 1441;
  localparam int K_GU = 354;
  localparam int K_GV = 734;
  localparam int K_BU = 1822;
  localparam int ADDR_MASK = (1 << ADDR_W) - 1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  first;
    logic [PIX_W-1:0]  second;
    logic [1:0]        bytes;
    logic [2:0]        stride;
    logic              last;
  } pixel_pair_t;

  pixel_pair_t expected_pairs[$];

  // register copy and frame walk
  int          disp_w;
  int          frame_w;
  int          frame_h;
  pixel_mode_t mode;
  int          col;
  int          row;
  int          row_base;

  function automatic int sat_dim(input int v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  // floor of a q10 sum, clamped to a byte
  function automatic logic [7:0] clamp_q10(input int t);
    if (t < 0) return 8'd0;
    if ((t >> 10) > 255) return 8'd255;
    return 8'(t >> 10);
  endfunction

  function automatic logic [PIX_W-1:0] convert_pixel(input logic [7:0] y, input logic [7:0] u,
                                                     input logic [7:0] v, input bit as565);
    int yy, du, dv;
    logic [7:0] r, g, b;
    yy = int'(y) * 1024;
    du = int'(u) - 128;
    dv = int'(v) - 128;
    r = clamp_q10(yy + K_RV * dv);
    g = clamp_q10(yy - K_GU * du - K_GV * dv);
    b = clamp_q10(yy + K_BU * du);
    if (as565) return {8'd0, r[7:3], g[7:2], b[7:3]};
    return {r, g, b};
  endfunction

  always @(posedge clk) begin : track
    pixel_pair_t want, got;
    int bpp, dw, fw, fh, pairs, rows, offset;
    bit last_col, last_row;
    if (rst) begin
      disp_w = DISPLAY_WIDTH_RST;
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
      mode = MODE_BGRX32;
      col = 0;
      row = 0;
      row_base = 0;
      expected_pairs.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {byte_address, pixel_first, pixel_second, bytes_written, pixel_stride, frame_end};
        if (expected_pairs.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing expected, addr %h first %h second %h",
                     $time, byte_address, pixel_first, pixel_second);
          fail_count++;
        end else begin
          want = expected_pairs.pop_front();
          results_checked++;
          if (got !== want) begin
            if (fail_count < 10)
              $display({"%0t: mismatch (expected/actual) addr %h/%h first %h/%h second %h/%h",
                        " bytes %0d/%0d stride %0d/%0d end %0d/%0d"}, $time,
                       want.addr, got.addr, want.first, got.first, want.second, got.second,
                       want.bytes, got.bytes, want.stride, got.stride, want.last, got.last);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_DISPLAY_WIDTH: disp_w = int'(cfg_data);
          REG_FRAME_WIDTH:   frame_w = int'(cfg_data);
          REG_FRAME_HEIGHT:  frame_h = int'(cfg_data);
          REG_PIXEL_MODE:    mode = pixel_mode_t'(cfg_data[1:0]);
        endcase
      end

      // the unsupported mode drops the item and leaves the walk alone
      if (in_valid && !in_stall && mode != MODE_NONE) begin
        bpp = (mode == MODE_RGB565) ? 2 : ((mode == MODE_BGR24) ? 3 : 4);
        dw = sat_dim(disp_w);
        fw = sat_dim(frame_w);
        fh = sat_dim(frame_h);
        pairs = fw / 2;
        if (pairs == 0) pairs = 1;
        rows = (fh == 0) ? 1 : fh;
        offset = (dw > fw) ? ((dw - fw) / 2) * bpp : 0;
        last_col = (col + 1 >= pairs);
        last_row = (row + 1 >= rows);
        want.addr = ADDR_W'(row_base + offset + col * 2 * bpp);
        want.first = convert_pixel(luma_first, chroma_blue, chroma_red, mode == MODE_RGB565);
        want.second = convert_pixel(luma_second, chroma_blue, chroma_red, mode == MODE_RGB565);
        want.bytes = (mode == MODE_RGB565) ? 2'd2 : 2'd3;
        want.stride = 3'(bpp);
        want.last = last_col && last_row;
        expected_pairs.push_back(want);
        if (!last_col) begin
          col++;
        end else if (!last_row) begin
          col = 0;
          row++;
          row_base = (row_base + dw * bpp) & ADDR_MASK;
        end else begin
          col = 0;
          row = 0;
          row_base = 0;
        end
      end
    end
    pending <= expected_pairs.size();
  end

endmodule

[tb/yuyv_to_rgb_framebuffer_test.sv]
`timescale 1ns / 1ps
// top of the yuyv to rgb framebuffer testbench: clock, reset, register writes, item
// stimulus with idle bursts, and the verdict; depends on yrfb_pkg, yrfb_pixel_checker
// and the yuyv_to_rgb_framebuffer block
module yuyv_to_rgb_framebuffer_test;
  import yrfb_pkg::*;

  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_AFTER   = 1300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        luma_first = '0;
  logic [7:0]        chroma_blue = '0;
  logic [7:0]        luma_second = '0;
  logic [7:0]        chroma_red = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] byte_address;
  logic [PIX_W-1:0]  pixel_first;
  logic [PIX_W-1:0]  pixel_second;
  logic [1:0]        bytes_written;
  logic [2:0]        pixel_stride;
  logic              frame_end;

  int fail_count;
  int pending;
  int results_checked;

  bit          gaps_on = 1'b0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  yuyv_to_rgb_framebuffer u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .luma_first(luma_first), .chroma_blue(chroma_blue),
    .luma_second(luma_second), .chroma_red(chroma_red),
    .out_valid(out_valid), .out_stall(out_stall),
    .byte_address(byte_address), .pixel_first(pixel_first), .pixel_second(pixel_second),
    .bytes_written(bytes_written), .pixel_stride(pixel_stride), .frame_end(frame_end)
  );

  yrfb_pixel_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .luma_first(luma_first), .chroma_blue(chroma_blue),
    .luma_second(luma_second), .chroma_red(chroma_red),
    .out_valid(out_valid), .out_stall(out_stall),
    .byte_address(byte_address), .pixel_first(pixel_first), .pixel_second(pixel_second),
    .bytes_written(bytes_written), .pixel_stride(pixel_stride), .frame_end(frame_end),
    .fail_count(fail_count), .pending(pending), .results_checked(results_checked)
  );

  // receiver: short random stall bursts, or one long hold on request
  always begin : receiver
    @(posedge clk);
    if (holds_done != hold_requests) begin
      holds_done++;
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      out_stall <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    #3000000;
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_config(input int dw, input int fw, input int fh, input pixel_mode_t mode);
    write_reg(REG_DISPLAY_WIDTH, dw);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_PIXEL_MODE, int'(mode));
    cfg_valid <= 1'b0;
  endtask

  // word is {y0, u, y1, v}
  task automatic send_item(input logic [31:0] word);
    if (gaps_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {luma_first, chroma_blue, luma_second, chroma_red} <= word;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // stop offering, let every expected pair come back, then cover the pipeline depth
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      6: w = {{8{w[31]}}, {8{w[23]}}, {8{w[15]}}, {8{w[7]}}};
      7: begin
        // chroma near the midpoint
        w[23:16] = 8'(120 + $urandom_range(0, 16));
        w[7:0] = 8'(120 + $urandom_range(0, 16));
      end
      8: begin
        w[31:24] = {8{w[31]}};
        w[15:8] = {8{w[15]}};
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 4096;
      4: return 4097;
      5: return 8191;
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  initial begin : stimulus
    int n, dw, fw, fh, phases, random_start;
    pixel_mode_t mode;
    phases = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, byte extremes
    gaps_on = 1'b1;
    stall_pct <= 10;
    send_item(32'h00000000);
    send_item(32'hFFFFFFFF);
    send_item(32'h00FFFF00);
    send_item(32'hFF0000FF);
    send_item(32'h80808080);
    wait_idle();

    // small frame in rgb565, the walk carries over from the frame before
    write_config(8, 4, 2, MODE_RGB565);
    send_item(32'h1080EB80);
    send_item(32'h0000FFFF);
    send_item(32'hFFFF0000);
    send_item(32'h515A91F0);
    wait_idle();

    // frame wider than the display
    write_config(2, 6, 1, MODE_BGR24);
    send_item(32'h7F01FE80);
    send_item(32'h01FE7F02);
    send_item(32'hC0407F3F);
    wait_idle();

    // unsupported mode, items dropped
    write_config(2, 6, 1, MODE_NONE);
    send_item(32'h12345678);
    send_item(32'hFFFFFFFF);
    send_item(32'h00000000);
    wait_idle();

    // zero width, zero height, zero display
    write_config(0, 0, 0, MODE_BGRX32);
    send_item(32'hAA55AA55);
    send_item(32'h55AA55AA);
    wait_idle();

    // frame width below one pair, display above the maximum
    write_config(4097, 1, 1, MODE_RGB565);
    send_item(32'hFF80FF80);
    send_item(32'h00800080);
    wait_idle();

    // odd width, display and height at full scale
    write_config(8191, 5, 8191, MODE_BGR24);
    send_item(32'h3CC3A55A);
    send_item(32'hE01F07F8);
    send_item(32'h0FF0F00F);
    wait_idle();
    phases = 7;

    // long receiver hold while the sender keeps offering
    write_config(20, 10, 4, MODE_BGRX32);
    gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 60; i++) send_item(random_word());
    wait_idle();
    phases++;

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        dw = $urandom_range(0, 48);
        fw = $urandom_range(0, 16);
        fh = $urandom_range(0, 5);
      end else begin
        dw = pick_dim();
        fw = pick_dim();
        fh = pick_dim();
      end
      mode = ($urandom_range(0, 9) == 0) ? MODE_NONE : pixel_mode_t'($urandom_range(0, 2));
      n = $urandom_range(10, 80);
      if (items_sent - random_start >= CALM_AFTER) begin
        gaps_on = 1'b0;
        stall_pct <= 0;
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);
        stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      write_config(dw, fw, fh, mode);
      for (int i = 0; i < n; i++) send_item(random_word());
      wait_idle();
      phases++;
    end

    $display("run covered %0d pixel pairs over %0d register settings, %0d results compared",
             items_sent, phases, results_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
